// ===== rtl/u8dv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8dv_pkg
// Shared types and constants for the strict UTF-8 decoder/validator.
// ----------------------------------------------------------------------------
package u8dv_pkg;

  localparam int unsigned CP_W          = 21;
  localparam int unsigned QUEUE_DEPTH_D = 4;

  localparam logic [CP_W-1:0] MIN_CP_LEN2  = 21'h00080;
  localparam logic [CP_W-1:0] MIN_CP_LEN3  = 21'h00800;
  localparam logic [CP_W-1:0] MIN_CP_LEN4  = 21'h10000;
  localparam logic [CP_W-1:0] MAX_CP       = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LO      = 21'h0D800;
  localparam logic [CP_W-1:0] SURR_HI      = 21'h0DFFF;
  localparam logic [CP_W-1:0] HIGH_SURR_BASE = 21'h0D800;
  localparam logic [CP_W-1:0] LOW_SURR_BASE  = 21'h0DC00;

  localparam logic [2:0] SEQ_LEN1 = 3'd1;
  localparam logic [2:0] SEQ_LEN2 = 3'd2;
  localparam logic [2:0] SEQ_LEN3 = 3'd3;
  localparam logic [2:0] SEQ_LEN4 = 3'd4;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [CP_W-1:0] code_unit;
    logic            unit_last;
    logic            string_error;
  } out_item_t;

  // One decoded result waiting for the back end.
  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            last;
    logic            err;
    logic            pair;   // emit as a UTF-16 surrogate pair
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== rtl/utf8_decoder_validator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_decoder_validator_unit
// Strict streaming UTF-8 decoder with UTF-32 or UTF-16 output.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle. The front end decodes and validates each
// byte in the cycle it is accepted and writes any finished result into a
// queue of QUEUE_DEPTH entries at that same edge; the back end moves a queue
// entry into the output register whenever out_valid or out_stall is low. A
// code point above 0xFFFF in UTF-16 mode leaves as two units, high surrogate
// first; it took four bytes to arrive, so the queue keeps up and the input
// still runs at one byte per cycle. in_stall is the queue full flag and rises
// only when out_stall has held results back long enough to fill the queue.
// After an error, a string yields nothing more until its final byte, which
// produces a single result with string_error set. The mode bit is sampled
// when a code point completes.
module utf8_decoder_validator_unit #(
  parameter int unsigned QUEUE_DEPTH = u8dv_pkg::QUEUE_DEPTH_D
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  u8dv_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output u8dv_pkg::out_item_t out_item,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data
);
  import u8dv_pkg::*;

  q_stat_t  q_stat;
  logic     q_push, q_pop;
  q_entry_t q_push_data, q_pop_data;

  u8dv_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_stat      (q_stat),
    .q_push      (q_push),
    .q_push_data (q_push_data)
  );

  u8dv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .stat      (q_stat)
  );

  u8dv_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_data    (q_pop_data),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ===== rtl/u8dv_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8dv_front
// Byte classifier and sequence state: accepts bytes, builds code points,
// checks range and form, and pushes results into the queue.
// ----------------------------------------------------------------------------
module u8dv_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  u8dv_pkg::in_item_t in_item,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  u8dv_pkg::q_stat_t  q_stat,
  output logic               q_push,
  output u8dv_pkg::q_entry_t q_push_data
);
  import u8dv_pkg::*;

  logic [1:0]      rem_r, rem_nxt;
  logic [CP_W-1:0] pcp_r, pcp_nxt;
  logic [2:0]      len_r, len_nxt;
  logic            err_r, err_nxt;
  logic            utf16_r;

  logic            accept;
  logic            complete;
  logic [7:0]      b;
  logic            eos;
  logic [CP_W-1:0] cp;

  function automatic logic cp_ok(input logic [CP_W-1:0] c, input logic [2:0] len);
    logic ok;
    ok = 1'b1;
    if (len == SEQ_LEN2 && c < MIN_CP_LEN2) ok = 1'b0;
    if (len == SEQ_LEN3 && c < MIN_CP_LEN3) ok = 1'b0;
    if (len == SEQ_LEN4 && c < MIN_CP_LEN4) ok = 1'b0;
    if (c > MAX_CP) ok = 1'b0;
    if (c >= SURR_LO && c <= SURR_HI) ok = 1'b0;
    return ok;
  endfunction

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign b        = in_item.byte_value;
  assign eos      = in_item.end_of_string;

  always_comb begin
    rem_nxt     = rem_r;
    pcp_nxt     = pcp_r;
    len_nxt     = len_r;
    err_nxt     = err_r;
    complete    = 1'b0;
    cp          = '0;
    q_push      = 1'b0;
    q_push_data = '0;
    if (accept) begin
      if (!err_r) begin
        if (rem_r == 2'd0) begin
          if (!b[7]) begin
            pcp_nxt  = {13'd0, b};
            len_nxt  = SEQ_LEN1;
            complete = 1'b1;
          end else if (b[7:5] == 3'b110) begin
            pcp_nxt = {16'd0, b[4:0]};
            len_nxt = SEQ_LEN2;
            rem_nxt = 2'd1;
          end else if (b[7:4] == 4'b1110) begin
            pcp_nxt = {17'd0, b[3:0]};
            len_nxt = SEQ_LEN3;
            rem_nxt = 2'd2;
          end else if (b[7:3] == 5'b11110) begin
            pcp_nxt = {18'd0, b[2:0]};
            len_nxt = SEQ_LEN4;
            rem_nxt = 2'd3;
          end else begin
            err_nxt = 1'b1;
          end
        end else if (b[7:6] != 2'b10) begin
          err_nxt = 1'b1;
        end else begin
          pcp_nxt = {pcp_r[CP_W-7:0], b[5:0]};
          rem_nxt = rem_r - 2'd1;
          if (rem_r == 2'd1) complete = 1'b1;
        end

        if (complete) begin
          cp = pcp_nxt;
          if (!cp_ok(cp, len_nxt)) begin
            err_nxt = 1'b1;
          end else begin
            q_push                 = 1'b1;
            q_push_data.code_point = cp;
            q_push_data.last       = eos;
            q_push_data.err        = 1'b0;
            q_push_data.pair       = utf16_r && (cp[CP_W-1:16] != '0);
          end
          pcp_nxt = '0;
          len_nxt = '0;
        end

        // truncated final sequence
        if (eos && !err_nxt && rem_nxt != 2'd0) err_nxt = 1'b1;
      end

      if (eos) begin
        if (err_nxt) begin
          q_push                 = 1'b1;
          q_push_data.code_point = '0;
          q_push_data.last       = 1'b1;
          q_push_data.err        = 1'b1;
          q_push_data.pair       = 1'b0;
        end
        rem_nxt = '0;
        pcp_nxt = '0;
        len_nxt = '0;
        err_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r   <= '0;
      pcp_r   <= '0;
      len_r   <= '0;
      err_r   <= 1'b0;
      utf16_r <= 1'b0;
    end else begin
      rem_r <= rem_nxt;
      pcp_r <= pcp_nxt;
      len_r <= len_nxt;
      err_r <= err_nxt;
      if (cfg_wr_en) utf16_r <= cfg_wr_data;
    end
  end

endmodule

// ===== rtl/u8dv_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8dv_queue
// Small FIFO of decoded results between the front and the back end.
// ----------------------------------------------------------------------------
module u8dv_queue #(
  parameter int unsigned DEPTH = u8dv_pkg::QUEUE_DEPTH_D
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  u8dv_pkg::q_entry_t push_data,
  input  logic               pop,
  output u8dv_pkg::q_entry_t pop_data,
  output u8dv_pkg::q_stat_t  stat
);
  import u8dv_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  q_entry_t         mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign stat.full  = (cnt_r == FULL_CNT);
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// ===== rtl/u8dv_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8dv_back
// Result emitter: drains the queue into the output register and splits
// supplementary code points into surrogate pairs.
// ----------------------------------------------------------------------------
module u8dv_back (
  input  logic                clk,
  input  logic                rst_n,
  input  u8dv_pkg::q_entry_t  q_data,
  input  u8dv_pkg::q_stat_t   q_stat,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output u8dv_pkg::out_item_t out_item
);
  import u8dv_pkg::*;

  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_item_r, out_item_nxt;
  logic       phase_r, phase_nxt;   // high surrogate already sent
  logic       can_load;
  logic [19:0] v;

  assign can_load  = !out_valid_r || !out_stall;
  assign v         = 20'(q_data.code_point - MIN_CP_LEN4);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    phase_nxt     = phase_r;
    q_pop         = 1'b0;
    if (can_load) begin
      out_valid_nxt = !q_stat.empty;
      if (!q_stat.empty) begin
        out_item_nxt.string_error = q_data.err;
        if (q_data.pair && !phase_r) begin
          out_item_nxt.code_unit = HIGH_SURR_BASE + {11'd0, v[19:10]};
          out_item_nxt.unit_last = 1'b0;
          phase_nxt              = 1'b1;
        end else if (q_data.pair) begin
          out_item_nxt.code_unit = LOW_SURR_BASE + {11'd0, v[9:0]};
          out_item_nxt.unit_last = q_data.last;
          phase_nxt              = 1'b0;
          q_pop                  = 1'b1;
        end else begin
          out_item_nxt.code_unit = q_data.code_point;
          out_item_nxt.unit_last = q_data.last;
          q_pop                  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

endmodule
